FILE: design/ssts_pkg.sv
package ssts_pkg;

   localparam int VALUE_W   = 32;
   localparam int CAP_W     = 6;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   // command queue between front and back
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = 1;
   localparam int Q_CNT_W   = 2;

   typedef enum logic {
      CMD_PUSH = 1'b0,   // push only
      CMD_SORT = 1'b1    // push, then sort and emit the set
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_out_type;

endpackage

FILE: design/ssts_front.sv
module ssts_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_i,
   output logic                 busy_o,
   input  logic [31:0]          value_i,
   input  logic                 is_last_i,
   output ssts_pkg::q_out_type  q_o,
   input  logic                 pop_i
);
   import ssts_pkg::*;

   cmd_type              q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;
   logic                 pop;
   cmd_type              new_cmd;

   assign busy_o = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign push   = start_i && !busy_o;
   assign pop    = pop_i && (count_ff != '0);

   // classify: the last word of a set triggers the sort
   always_comb begin
      new_cmd.value = value_i;
      new_cmd.kind  = is_last_i ? CMD_SORT : CMD_PUSH;
   end

   always_comb begin
      wr_ptr_in = push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = Q_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = Q_CNT_W'(count_ff - 1'b1);
      end
   end

   assign q_o.valid = (count_ff != '0);
   assign q_o.cmd   = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == Q_PTR_W'(rd_ptr_ff + count_ff))
      else $error("queue pointers disagree with count");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == Q_CNT_W'($past(count_ff) + 1'b1))
      else $error("queue push lost");

endmodule

FILE: design/ssts_back.sv
module ssts_back #(
   parameter int DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ssts_pkg::q_out_type             q_i,
   output logic                            pop_o,
   input  logic [$clog2(DEPTH+1)-1:0]      cap_i,
   output logic                            rsp_strobe_o,
   output logic signed [31:0]              rsp_sorted_value_o,
   output logic                            rsp_end_of_set_o,
   output logic                            rsp_overflowed_o
);
   import ssts_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   typedef enum logic [3:0] {
      S_LOAD = 4'b0001,
      S_POP  = 4'b0010,
      S_CMP  = 4'b0100,
      S_EMIT = 4'b1000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     in_top_ff, in_top_in;
   logic [CNT_W-1:0]     tmp_top_ff, tmp_top_in;
   logic [CNT_W-1:0]     emit_idx_ff, emit_idx_in;
   logic                 drop_ff, drop_in;
   logic                 strobe_ff, strobe_in;
   logic                 end_ff, end_in;
   logic                 ovf_ff, ovf_in;

   logic [31:0]          input_stack [DEPTH];
   logic [31:0]          temp_stack  [DEPTH];
   logic [31:0]          in_rd_ff;
   logic [31:0]          tmp_rd_ff;

   logic                 in_wr_en, in_rd_en, tmp_wr_en, tmp_rd_en;
   logic [IDX_W-1:0]     in_wr_addr, in_rd_addr, tmp_wr_addr, tmp_rd_addr;
   logic [31:0]          in_wr_data;

   logic [CNT_W-1:0]     in_dec, tmp_dec1, tmp_dec2;
   logic                 greater;

   assign in_dec   = in_top_ff - CNT_W'(1);
   assign tmp_dec1 = tmp_top_ff - CNT_W'(1);
   assign tmp_dec2 = tmp_top_ff - CNT_W'(2);
   // in_rd_ff holds the popped word, tmp_rd_ff the current top of the temp stack
   assign greater  = $signed(tmp_rd_ff) > $signed(in_rd_ff);
   assign pop_o    = (state_ff == S_LOAD) && q_i.valid;

   always_comb begin
      state_in    = state_ff;
      in_top_in   = in_top_ff;
      tmp_top_in  = tmp_top_ff;
      emit_idx_in = emit_idx_ff;
      drop_in     = drop_ff;
      strobe_in   = 1'b0;
      end_in      = 1'b0;
      ovf_in      = drop_ff;
      in_wr_en    = 1'b0;
      in_wr_addr  = in_top_ff[IDX_W-1:0];
      in_wr_data  = q_i.cmd.value;
      in_rd_en    = 1'b0;
      in_rd_addr  = in_dec[IDX_W-1:0];
      tmp_wr_en   = 1'b0;
      tmp_wr_addr = tmp_top_ff[IDX_W-1:0];
      tmp_rd_en   = 1'b0;
      tmp_rd_addr = tmp_dec1[IDX_W-1:0];
      case (state_ff)
         S_LOAD: begin
            if (q_i.valid) begin
               if (in_top_ff < cap_i) begin
                  in_wr_en  = 1'b1;
                  in_top_in = in_top_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (q_i.cmd.kind == CMD_SORT) begin
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            if (in_top_ff != '0) begin
               in_rd_en  = 1'b1;
               tmp_rd_en = 1'b1;
               in_top_in = in_dec;
               state_in  = S_CMP;
            end else if (tmp_top_ff == '0) begin
               drop_in  = 1'b0;
               state_in = S_LOAD;
            end else begin
               emit_idx_in = '0;
               state_in    = S_EMIT;
            end
         end
         S_CMP: begin
            if ((tmp_top_ff != '0) && greater) begin
               // move the larger top back and fetch the next one down
               in_wr_en    = 1'b1;
               in_wr_data  = tmp_rd_ff;
               in_top_in   = in_top_ff + CNT_W'(1);
               tmp_top_in  = tmp_dec1;
               tmp_rd_en   = 1'b1;
               tmp_rd_addr = tmp_dec2[IDX_W-1:0];
            end else begin
               tmp_wr_en  = 1'b1;
               tmp_top_in = tmp_top_ff + CNT_W'(1);
               state_in   = S_POP;
            end
         end
         S_EMIT: begin
            tmp_rd_en   = 1'b1;
            tmp_rd_addr = emit_idx_ff[IDX_W-1:0];
            strobe_in   = 1'b1;
            emit_idx_in = emit_idx_ff + CNT_W'(1);
            if (emit_idx_ff == tmp_dec1) begin
               end_in      = 1'b1;
               tmp_top_in  = '0;
               emit_idx_in = '0;
               drop_in     = 1'b0;
               state_in    = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (in_wr_en) begin
         input_stack[in_wr_addr] <= in_wr_data;
      end
      if (in_rd_en) begin
         in_rd_ff <= input_stack[in_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tmp_wr_en) begin
         temp_stack[tmp_wr_addr] <= in_rd_ff;
      end
      if (tmp_rd_en) begin
         tmp_rd_ff <= temp_stack[tmp_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         in_top_ff   <= '0;
         tmp_top_ff  <= '0;
         emit_idx_ff <= '0;
         drop_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_top_ff   <= in_top_in;
         tmp_top_ff  <= tmp_top_in;
         emit_idx_ff <= emit_idx_in;
         drop_ff     <= drop_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      ovf_ff <= ovf_in;
   end

   assign rsp_strobe_o       = strobe_ff;
   assign rsp_sorted_value_o = $signed(tmp_rd_ff);
   assign rsp_end_of_set_o   = end_ff;
   assign rsp_overflowed_o   = ovf_ff;

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == S_EMIT))
      else $error("result strobe outside emit");

   a_end_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && end_ff) |-> (state_ff == S_LOAD) && (tmp_top_ff == '0))
      else $error("set not closed after final word");

   a_words_conserved: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, in_top_ff} + {1'b0, tmp_top_ff}) <= (CNT_W+1)'(DEPTH))
      else $error("stacks hold more words than depth");

endmodule

FILE: design/stack_sort_two_stack_top.sv
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+------------------------------
// request   | req_value, req_is_last                         | taken when start & !busy
// response  | rsp_sorted_value, rsp_end_of_set, rsp_overflowed| one cycle, marked by rsp_strobe
// control   | csr_wdata (capacity)                           | written when csr_we is high
//
// A request word is taken and queued; while loading, the back end pushes one queued word a cycle.
// Sorting a set of n words pops each word in turn and moves words back from the temp stack
// (up to n*(n-1)/2 moves), paced by the single read port of each stack memory; the first
// emitted word appears in the cycle after emission starts.
// Reset (synchronous, active high) empties both stacks and the queue and sets capacity to 32.
// busy rises while the queue is full; the receiver cannot stall, so results are never held.
module stack_sort_two_stack_top #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic               req_is_last,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_sorted_value,
   output logic               rsp_end_of_set,
   output logic               rsp_overflowed,
   input  logic               csr_we,
   input  logic [5:0]         csr_wdata
);
   import ssts_pkg::*;

   localparam int CNT_W = $clog2(DEPTH+1);

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [7:0]        cap_wide;
   logic [CNT_W-1:0]  eff_cap;
   q_out_type         q_bus;
   logic              q_pop;

   // hold the capacity; the user must write it only while the block is idle, the block does not enforce this
   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // clamp: zero behaves as one, anything past the stack depth as the depth
   assign cap_wide = {2'b00, capacity_ff};

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (cap_wide > 8'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_wide);
      end
   end

   // front: take and classify words, queue them for the back end
   ssts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start_i   (start),
      .busy_o    (busy),
      .value_i   (req_value),
      .is_last_i (req_is_last),
      .q_o       (q_bus),
      .pop_i     (q_pop)
   );

   // back: push, sort with two stacks, emit ascending
   ssts_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_i                (q_bus),
      .pop_o              (q_pop),
      .cap_i              (eff_cap),
      .rsp_strobe_o       (rsp_strobe),
      .rsp_sorted_value_o (rsp_sorted_value),
      .rsp_end_of_set_o   (rsp_end_of_set),
      .rsp_overflowed_o   (rsp_overflowed)
   );

endmodule

FILE: tb/stack_sort_two_stack_top_tb.sv
module stack_sort_two_stack_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssts_pkg::*;

   localparam int DEPTH      = 32;
   localparam int SETTLE     = 40;         // idle cycles granted before a capacity write
   localparam int WORD_GOAL  = 360;
   localparam int GAP_PCT    = 31;
   localparam int LIMIT_NS   = 2_000_000;

   // kinds of entry in the pending stimulus queue
   typedef enum logic [1:0] {
      STIM_WORD  = 2'd0,   // one request word
      STIM_CAP   = 2'd1,   // capacity write, issued only once the block is idle
      STIM_DRAIN = 2'd2    // hold the sender until every sorted word has come back
   } stim_kind_type;

   typedef struct {
      stim_kind_type          kind;
      logic signed [31:0]     value;
      logic                   is_last;
      logic                   eager;     // never idle in front of this word
      logic [CAP_W-1:0]       cap;
   } stim_type;

   typedef struct {
      logic signed [31:0] sorted_value;
      logic               end_of_set;
      logic               overflowed;
   } sorted_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_value = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_sorted_value;
   logic               rsp_end_of_set;
   logic               rsp_overflowed;
   logic               csr_we = 1'b0;
   logic [CAP_W-1:0]   csr_wdata = '0;

   stim_type           stim_q[$];
   sorted_word_type    sorted_due[$];
   int                 error_count = 0;
   int                 word_total = 0;

   // Shadow of the sorter: the load stack takes arriving words, the hold stack
   // collects them in ascending order during the sort.
   logic signed [31:0] load_stack [DEPTH];
   logic signed [31:0] hold_stack [DEPTH];
   int unsigned        load_cnt = 0;
   int unsigned        hold_cnt = 0;
   logic               drop_flag = 1'b0;
   logic [CAP_W-1:0]   cap_shadow = CAP_RESET;

   stack_sort_two_stack_top #(.DEPTH(DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set),
      .rsp_overflowed   (rsp_overflowed),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Capacity zero behaves as one, anything past the stack depth as the depth.
   function automatic int unsigned room_for(input logic [CAP_W-1:0] cap);
      if (cap == 0)
         return 1;
      else if (cap > DEPTH)
         return DEPTH;
      else
         return cap;
   endfunction

   // Push (or drop) one accepted word; on the last word of a set, sort the set
   // through the two stacks and queue the sorted words it must produce.
   task automatic sort_shadow(input logic signed [31:0] value, input logic is_last);
      logic signed [31:0] cur;
      sorted_word_type    w;
      if (load_cnt < room_for(cap_shadow)) begin
         load_stack[load_cnt] = value;
         load_cnt++;
      end else begin
         drop_flag = 1'b1;
      end
      if (is_last) begin
         hold_cnt = 0;
         while (load_cnt > 0) begin
            load_cnt--;
            cur = load_stack[load_cnt];
            // move strictly larger words back; equal ones stay, keeping pop order
            while (hold_cnt > 0 && hold_stack[hold_cnt-1] > cur) begin
               hold_cnt--;
               load_stack[load_cnt] = hold_stack[hold_cnt];
               load_cnt++;
            end
            hold_stack[hold_cnt] = cur;
            hold_cnt++;
         end
         // emit bottom first, so the order is ascending
         for (int unsigned k = 0; k < hold_cnt; k++) begin
            w.sorted_value = hold_stack[k];
            w.end_of_set   = (k + 1 == hold_cnt);
            w.overflowed   = drop_flag;
            sorted_due.push_back(w);
         end
         load_cnt  = 0;
         hold_cnt  = 0;
         drop_flag = 1'b0;
      end
   endtask

   task automatic add_word(input logic signed [31:0] value, input logic is_last);
      stim_type s;
      s.kind    = STIM_WORD;
      s.value   = value;
      s.is_last = is_last;
      // a stretch in the middle of the run goes with no idling at all
      s.eager   = (word_total >= 150 && word_total < 230);
      s.cap     = '0;
      stim_q.push_back(s);
      word_total++;
   endtask

   task automatic add_ctrl(input stim_kind_type kind, input logic [CAP_W-1:0] cap);
      stim_type s;
      s.kind    = kind;
      s.value   = '0;
      s.is_last = 1'b0;
      s.eager   = 1'b0;
      s.cap     = cap;
      stim_q.push_back(s);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $signed($urandom_range(0, 6)) - 3;   // crowd of near-equal words
         1: case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh00000000;
               default: return -32'sd1;
            endcase
         default: return $urandom;
      endcase
   endfunction

   // Driver: hold a word on the request ports until it is taken, then advance.
   always @(posedge clock) begin : drive_proc
      logic     nxt_start;
      logic     nxt_we;
      stim_type nx;
      int       settle_cnt;
      if (reset) begin
         start      <= 1'b0;
         csr_we     <= 1'b0;
         settle_cnt = 0;
      end else begin
         nxt_start = start;
         nxt_we    = 1'b0;
         // count cycles with nothing in flight and nothing owed
         if (sorted_due.size() == 0 && !start)
            settle_cnt++;
         else
            settle_cnt = 0;
         if (start && !busy) begin
            sort_shadow(req_value, req_is_last);
            nxt_start = 1'b0;
         end
         if (!nxt_start && stim_q.size() > 0) begin
            nx = stim_q[0];
            case (nx.kind)
               STIM_WORD: begin
                  if (nx.eager || $urandom_range(0, 99) >= GAP_PCT) begin
                     req_value   <= nx.value;
                     req_is_last <= nx.is_last;
                     nxt_start   = 1'b1;
                     stim_q.delete(0);
                  end
               end
               STIM_CAP: begin
                  // write only once the block has gone quiet
                  if (settle_cnt >= SETTLE) begin
                     csr_wdata  <= nx.cap;
                     nxt_we     = 1'b1;
                     cap_shadow = nx.cap;
                     settle_cnt = 0;
                     stim_q.delete(0);
                  end
               end
               default: begin
                  if (settle_cnt >= SETTLE)
                     stim_q.delete(0);
               end
            endcase
         end
         start  <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // Monitor: each strobed word must match the oldest word owed.
   always @(posedge clock) begin : watch_proc
      sorted_word_type w;
      if (!reset && rsp_strobe === 1'b1) begin
         if (sorted_due.size() == 0) begin
            $display("%0t: unexpected sorted word: expected none, actual %h eos %b ovf %b",
                     $time, rsp_sorted_value, rsp_end_of_set, rsp_overflowed);
            error_count++;
         end else begin
            w = sorted_due.pop_front();
            if (rsp_sorted_value !== w.sorted_value) begin
               $display("%0t: sorted_value mismatch: expected %h, actual %h",
                        $time, w.sorted_value, rsp_sorted_value);
               error_count++;
            end
            if (rsp_end_of_set !== w.end_of_set) begin
               $display("%0t: end_of_set mismatch: expected %b, actual %b",
                        $time, w.end_of_set, rsp_end_of_set);
               error_count++;
            end
            if (rsp_overflowed !== w.overflowed) begin
               $display("%0t: overflowed mismatch: expected %b, actual %b",
                        $time, w.overflowed, rsp_overflowed);
               error_count++;
            end
         end
      end
   end

   // Stimulus, then the end of the run.
   initial begin : stim_proc
      int unsigned      room;
      int unsigned      nsets;
      int unsigned      len;
      logic [CAP_W-1:0] cap;

      // Directed words at the default capacity: both extremes, zero, minus one,
      // and a pair of equal words that must keep their order.
      add_word(32'sh7fffffff, 1'b0);
      add_word(32'sh80000000, 1'b0);
      add_word(32'sh00000000, 1'b0);
      add_word(-32'sd1, 1'b0);
      add_word(32'sd5, 1'b0);
      add_word(32'sd5, 1'b0);
      add_word(32'sd1, 1'b1);
      // capacity zero acts as one: the last word is dropped yet the set is emitted
      add_ctrl(STIM_CAP, 6'd0);
      add_word(32'sd3, 1'b0);
      add_word(32'sd7, 1'b1);
      // capacity past the depth acts as the depth
      add_ctrl(STIM_CAP, 6'd63);
      add_word(-32'sd42, 1'b1);
      // full stack at a small capacity
      add_ctrl(STIM_CAP, 6'd2);
      add_word(32'sd9, 1'b0);
      add_word(-32'sd9, 1'b0);
      add_word(32'sd4, 1'b1);
      add_ctrl(STIM_CAP, 6'd1);
      add_word(32'sh12345678, 1'b1);
      // descending and ascending input: fewest and most moves back
      add_ctrl(STIM_CAP, 6'd3);
      add_word(32'sd30, 1'b0);
      add_word(32'sd20, 1'b0);
      add_word(32'sd10, 1'b1);
      add_word(-32'sd1, 1'b0);
      add_word(32'sd0, 1'b0);
      add_word(32'sd1, 1'b1);
      add_ctrl(STIM_DRAIN, '0);

      // Random phases: a fresh capacity, then a few sets, some of them overfilled.
      while (word_total < WORD_GOAL) begin
         case ($urandom_range(0, 9))
            0:       cap = 6'd0;
            1:       cap = 6'd63;
            2:       cap = CAP_W'($urandom_range(33, 62));
            3:       cap = 6'd32;
            4:       cap = 6'd1;
            default: cap = CAP_W'($urandom_range(2, 12));
         endcase
         add_ctrl(STIM_CAP, cap);
         room  = room_for(cap);
         nsets = $urandom_range(1, 4);
         for (int unsigned s = 0; s < nsets; s++) begin
            if ($urandom_range(0, 3) == 0)
               len = $urandom_range(1, room + 3);
            else
               len = $urandom_range(1, (room > 8) ? 8 : room);
            for (int unsigned i = 0; i < len; i++)
               add_word(pick_value(), i + 1 == len);
         end
         // now and then hold the sender until every owed word is back
         if ($urandom_range(0, 2) == 0)
            add_ctrl(STIM_DRAIN, '0);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to drain and every sorted word to arrive.
      while (stim_q.size() != 0 || start || sorted_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0)
         $display("stack_sort_two_stack_top test passed");
      else
         $display("stack_sort_two_stack_top test failed");
      $finish;
   end

   initial begin : limit_proc
      #LIMIT_NS;
      $display("stack_sort_two_stack_top test failed");
      $finish;
   end

endmodule
